>>> hdl/sra_pkg.sv
// Shared types, codes and constants of the spectrum resample aggregate unit.
package sra_pkg;

   localparam int BIN_DEPTH_DEF   = 512;
   localparam int SWEEP_DEPTH_DEF = 512;
   localparam int FRAC_BITS_DEF   = 8;

   localparam int VALUE_W  = 24;
   localparam int FREQ_W   = 32;
   localparam int INDEX_W  = 9;
   localparam int HITS_W   = 16;
   localparam int ACCUM_W  = 32;
   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 40;

   localparam int HOLD_START = 1000 * 256;
   localparam int VAL_MAX    = 8388607;
   localparam int VAL_MIN    = -8388608;
   localparam logic [HITS_W-1:0] HITS_MAX = 16'hFFFF;

   // action codes on the request tuser
   localparam logic [1:0] ACT_CLEAR = 2'd0;
   localparam logic [1:0] ACT_PUSH  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // aggregation modes; any other code averages
   localparam logic [1:0] MODE_MIN = 2'd0;
   localparam logic [1:0] MODE_MAX = 2'd1;

   // register indexes
   localparam logic [1:0] REG_AGG_MODE   = 2'd0;
   localparam logic [1:0] REG_BIN_COUNT  = 2'd1;
   localparam logic [1:0] REG_GRID_START = 2'd2;
   localparam logic [1:0] REG_GRID_STOP  = 2'd3;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_PUSH,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [VALUE_W-1:0]  sample_value;
      logic                sample_last;
      logic [FREQ_W-1:0]   sweep_start_freq;
      logic [FREQ_W-1:0]   sweep_stop_freq;
      logic [INDEX_W-1:0]  bin_index;
   } cmd_type;

   typedef struct packed {
      logic pop;
      logic init_busy;
   } status_type;

   typedef struct packed {
      logic [1:0]        agg_mode;
      logic [9:0]        bin_count;
      logic [FREQ_W-1:0] grid_start_freq;
      logic [FREQ_W-1:0] grid_stop_freq;
   } cfg_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_CLEAR,
      S_MERGE_CHK,
      S_STEP_DIV,
      S_BIN,
      S_MUL,
      S_DIV_GO,
      S_POS_DIV,
      S_POS,
      S_RD_LO,
      S_RD_HI,
      S_CALC,
      S_WR,
      S_NEXT,
      S_READ,
      S_READ_CALC,
      S_READ_DIV,
      S_RESP
   } state_type;

endpackage

>>> hdl/spectrum_resample_aggregate_unit.sv
// Top level: CSR block, request front end and merge/readout back end.
// Push stores the sample in the sweep RAM; read fetches a bin, divides by its hits when averaging.
// A last sample runs a merge: one grid-step division, then for each bin that the sweep covers
// a bit-serial position division (none for a single-frequency sweep), sweep RAM reads and a bin update.
// Clear writes every bin RAM entry, one per cycle.
// Reset: synchronous; an init pass then zeroes the bin RAMs while req_tready stays low.
module spectrum_resample_aggregate_unit #(
   parameter int BIN_DEPTH   = sra_pkg::BIN_DEPTH_DEF,
   parameter int SWEEP_DEPTH = sra_pkg::SWEEP_DEPTH_DEF,
   parameter int FRAC_BITS   = sra_pkg::FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // [23:0] sample_value, [55:24] sweep_start_freq, [87:56] sweep_stop_freq,
   // [96:88] bin_index, [103:97] zero
   input  logic [103:0]  req_tdata,
   input  logic          req_tlast,
   // [1:0] action
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [23:0] bin_value, [39:24] bin_hits
   output logic [39:0]   rsp_tdata,
   // [0] bin_valid
   output logic          rsp_tuser,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [3:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   sra_pkg::cfg_type    cfg_ff, cfg_in;
   sra_pkg::status_type status;
   sra_pkg::cmd_type    head;
   logic                head_valid;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            sra_pkg::REG_AGG_MODE:   cfg_in.agg_mode        = csr_pwdata[1:0];
            sra_pkg::REG_BIN_COUNT:  cfg_in.bin_count       = csr_pwdata[9:0];
            sra_pkg::REG_GRID_START: cfg_in.grid_start_freq = csr_pwdata;
            sra_pkg::REG_GRID_STOP:  cfg_in.grid_stop_freq  = csr_pwdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         sra_pkg::REG_AGG_MODE:   csr_prdata = 32'(cfg_ff.agg_mode);
         sra_pkg::REG_BIN_COUNT:  csr_prdata = 32'(cfg_ff.bin_count);
         sra_pkg::REG_GRID_START: csr_prdata = cfg_ff.grid_start_freq;
         sra_pkg::REG_GRID_STOP:  csr_prdata = cfg_ff.grid_stop_freq;
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.agg_mode        <= 2'd2;
         cfg_ff.bin_count       <= 10'd512;
         cfg_ff.grid_start_freq <= '0;
         cfg_ff.grid_stop_freq  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sra_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .status     (status),
      .head_valid (head_valid),
      .head       (head)
   );

   sra_back #(
      .BIN_DEPTH   (BIN_DEPTH),
      .SWEEP_DEPTH (SWEEP_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head       (head),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_init_blocks_requests: assert property (@(posedge clock) disable iff (reset)
      status.init_busy |-> !req_tready)
      else $error("request accepted during bin RAM init");

   a_empty_bin_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("empty bin returned nonzero data");

   a_valid_matches_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == (rsp_tdata[39:24] != 16'd0))
      else $error("bin_valid disagrees with bin_hits");

endmodule

>>> hdl/sra_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module sra_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/sra_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module sra_div #(
   parameter int NW = 48,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   rem_sh;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

>>> hdl/sra_front.sv
// Request intake: decodes the action and queues commands for the back end.
module sra_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [sra_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tlast,
   input  logic [1:0]                      req_tuser,
   input  sra_pkg::status_type             status,
   output logic                            head_valid,
   output sra_pkg::cmd_type                head
);

   sra_pkg::cmd_type entry_ff [2];
   sra_pkg::cmd_type cmd;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             accept, keep, pop;

   assign req_tready = (count_ff != 2'd2) && !status.init_busy;
   assign accept     = req_tvalid && req_tready;
   assign pop        = status.pop && (count_ff != 2'd0);

   always_comb begin
      cmd.sample_value     = req_tdata[23:0];
      cmd.sweep_start_freq = req_tdata[55:24];
      cmd.sweep_stop_freq  = req_tdata[87:56];
      cmd.bin_index        = req_tdata[96:88];
      cmd.sample_last      = req_tlast;
      keep = 1'b1;
      case (req_tuser)
         sra_pkg::ACT_CLEAR: cmd.kind = sra_pkg::CMD_CLEAR;
         sra_pkg::ACT_PUSH:  cmd.kind = sra_pkg::CMD_PUSH;
         sra_pkg::ACT_READ:  cmd.kind = sra_pkg::CMD_READ;
         default: begin
            // unknown action: take the request and drop it
            cmd.kind = sra_pkg::CMD_CLEAR;
            keep     = 1'b0;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      count_in = count_ff + {1'b0, accept && keep} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (accept && keep) begin
         entry_ff[wr_ptr_ff] <= cmd;
      end
   end

   assign head_valid = (count_ff != 2'd0);
   assign head       = entry_ff[rd_ptr_ff];

endmodule

>>> hdl/sra_back.sv
// Command execution: bin RAM init and clear, sweep buffering, per-bin merge, bin readout.
module sra_back #(
   parameter int BIN_DEPTH   = sra_pkg::BIN_DEPTH_DEF,
   parameter int SWEEP_DEPTH = sra_pkg::SWEEP_DEPTH_DEF,
   parameter int FRAC_BITS   = sra_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sra_pkg::cfg_type                cfg,
   input  logic                            head_valid,
   input  sra_pkg::cmd_type                head,
   output sra_pkg::status_type             status,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sra_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tuser
);

   localparam int BIN_AW = $clog2(BIN_DEPTH);
   localparam int BCW    = $clog2(BIN_DEPTH + 1);
   localparam int IDXW   = $clog2(SWEEP_DEPTH);
   localparam int FW     = $clog2(SWEEP_DEPTH + 1);
   localparam int PRW    = 32 + IDXW;
   localparam int NW     = PRW + FRAC_BITS;
   localparam int IPW    = 26 + FRAC_BITS;

   sra_pkg::state_type state_ff, state_in;
   sra_pkg::cmd_type   cmd_ff, cmd_in;

   logic [BCW-1:0]  k_ff, k_in;
   logic [31:0]     f_ff, f_in;
   logic [31:0]     step_ff, step_in;
   logic [FW-1:0]   fill_ff, fill_in;
   logic [PRW-1:0]  prod_ff, prod_in;
   logic [IDXW-1:0] idx_ff, idx_in;
   logic [FRAC_BITS-1:0] frac_ff, frac_in;
   logic            use_hi_ff, use_hi_in;
   logic signed [23:0]    lo_ff, lo_in;
   logic signed [IPW-1:0] ip_ff, ip_in;
   logic signed [23:0]    mm_ff, mm_in;
   logic signed [32:0]    val_ff, val_in;
   logic [15:0]     hits_ff, hits_in;
   logic            neg_ff, neg_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [23:0]     rsp_value_ff, rsp_value_in;
   logic [15:0]     rsp_hits_ff, rsp_hits_in;
   logic            rsp_flag_ff, rsp_flag_in;

   // memory ports
   logic            sw_wr_en, sw_rd_en;
   logic [IDXW-1:0] sw_wr_addr, sw_rd_addr;
   logic [23:0]     sw_rd_data;
   logic              bin_wr_en, bin_rd_en;
   logic [BIN_AW-1:0] bin_wr_addr, bin_rd_addr;
   logic [31:0]       acc_wr_data, acc_rd_data;
   logic [15:0]       cnt_wr_data, cnt_rd_data;

   // divider
   logic          div_start, div_done;
   logic [NW-1:0] div_num, div_quot;
   logic [31:0]   div_den;

   // helpers
   logic [31:0]     bc_wide;
   logic [BCW-1:0]  bc;
   logic            last_entry, is_min, is_max, is_avg;
   logic            push_room, in_range, out_free, sweep_bad, bin_out;
   logic [IDXW-1:0] lenm1;
   logic [PRW-FRAC_BITS+FRAC_BITS-1:0] unused_pad;
   logic [NW-FRAC_BITS-1:0] pos_int;
   logic signed [31:0] clear_value, acc_s;
   logic signed [23:0] hi_s;
   logic signed [24:0] diff;
   logic signed [IPW:0] ip_rnd, ip_sh;
   logic signed [33:0]  v34, sum34;
   logic signed [31:0]  merged;
   logic                merge_ok;
   logic [32:0]         mag;
   logic signed [32:0]  q33;

   always_comb begin
      bc_wide = 32'(cfg.bin_count);
      if (bc_wide < 32'd2) begin
         bc_wide = 32'd2;
      end
      if (bc_wide > 32'(BIN_DEPTH)) begin
         bc_wide = 32'(BIN_DEPTH);
      end
      bc = BCW'(bc_wide);
   end

   assign is_min     = (cfg.agg_mode == sra_pkg::MODE_MIN);
   assign is_max     = (cfg.agg_mode == sra_pkg::MODE_MAX);
   assign is_avg     = !is_min && !is_max;
   assign last_entry = (k_ff == BCW'(BIN_DEPTH - 1));
   assign push_room  = (32'(fill_ff) < 32'(SWEEP_DEPTH));
   assign lenm1      = IDXW'(fill_ff - FW'(1));
   assign sweep_bad  = (fill_ff == '0) || (cmd_ff.sweep_stop_freq < cmd_ff.sweep_start_freq);
   assign bin_out    = (f_ff < cmd_ff.sweep_start_freq) || (f_ff > cmd_ff.sweep_stop_freq);
   assign in_range   = (32'(cmd_ff.bin_index) < 32'(BIN_DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign pos_int    = div_quot[NW-1:FRAC_BITS];
   assign unused_pad = '0;

   always_comb begin
      case (cfg.agg_mode)
         sra_pkg::MODE_MIN: clear_value = 32'(sra_pkg::HOLD_START);
         sra_pkg::MODE_MAX: clear_value = -32'(sra_pkg::HOLD_START);
         default:           clear_value = '0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sra_pkg::S_INIT: begin
            if (last_entry) state_in = sra_pkg::S_IDLE;
         end
         sra_pkg::S_IDLE: begin
            if (head_valid) begin
               case (head.kind)
                  sra_pkg::CMD_CLEAR: state_in = sra_pkg::S_CLEAR;
                  sra_pkg::CMD_PUSH: begin
                     if (head.sample_last) state_in = sra_pkg::S_MERGE_CHK;
                  end
                  sra_pkg::CMD_READ:  state_in = sra_pkg::S_READ;
                  default:            state_in = sra_pkg::S_IDLE;
               endcase
            end
         end
         sra_pkg::S_CLEAR: begin
            if (last_entry) state_in = sra_pkg::S_IDLE;
         end
         sra_pkg::S_MERGE_CHK: begin
            state_in = sweep_bad ? sra_pkg::S_IDLE : sra_pkg::S_STEP_DIV;
         end
         sra_pkg::S_STEP_DIV: begin
            if (div_done) state_in = sra_pkg::S_BIN;
         end
         sra_pkg::S_BIN: begin
            if (k_ff == bc) begin
               state_in = sra_pkg::S_IDLE;
            end else if (bin_out) begin
               state_in = sra_pkg::S_NEXT;
            end else if (cmd_ff.sweep_stop_freq == cmd_ff.sweep_start_freq) begin
               state_in = sra_pkg::S_RD_LO;
            end else begin
               state_in = sra_pkg::S_MUL;
            end
         end
         sra_pkg::S_MUL:     state_in = sra_pkg::S_DIV_GO;
         sra_pkg::S_DIV_GO:  state_in = sra_pkg::S_POS_DIV;
         sra_pkg::S_POS_DIV: begin
            if (div_done) state_in = sra_pkg::S_POS;
         end
         sra_pkg::S_POS:     state_in = sra_pkg::S_RD_LO;
         sra_pkg::S_RD_LO:   state_in = sra_pkg::S_RD_HI;
         sra_pkg::S_RD_HI:   state_in = sra_pkg::S_CALC;
         sra_pkg::S_CALC:    state_in = sra_pkg::S_WR;
         sra_pkg::S_WR:      state_in = sra_pkg::S_NEXT;
         sra_pkg::S_NEXT:    state_in = sra_pkg::S_BIN;
         sra_pkg::S_READ:    state_in = sra_pkg::S_READ_CALC;
         sra_pkg::S_READ_CALC: begin
            if (in_range && (cnt_rd_data != '0) && is_avg) begin
               state_in = sra_pkg::S_READ_DIV;
            end else begin
               state_in = sra_pkg::S_RESP;
            end
         end
         sra_pkg::S_READ_DIV: begin
            if (div_done) state_in = sra_pkg::S_RESP;
         end
         sra_pkg::S_RESP: begin
            if (out_free) state_in = sra_pkg::S_IDLE;
         end
         default: state_in = sra_pkg::S_IDLE;
      endcase
   end

   // merge arithmetic for the bin at hand
   always_comb begin
      hi_s   = use_hi_ff ? $signed(sw_rd_data) : lo_ff;
      diff   = 25'(hi_s) - 25'(lo_ff);
      acc_s  = $signed(acc_rd_data);
      ip_rnd = (IPW + 1)'(ip_ff) + ((IPW + 1)'(1) << (FRAC_BITS - 1));
      ip_sh  = ip_rnd >>> FRAC_BITS;
      v34    = 34'(lo_ff) + 34'(ip_sh);
      sum34  = 34'(acc_s) + v34;
      merge_ok = 1'b1;
      if (is_min) begin
         merged = (32'(mm_ff) < acc_s) ? 32'(mm_ff) : acc_s;
      end else if (is_max) begin
         merged = (32'(mm_ff) > acc_s) ? 32'(mm_ff) : acc_s;
      end else begin
         merge_ok = (cnt_rd_data != sra_pkg::HITS_MAX);
         if (sum34 > 34'sd2147483647) begin
            merged = 32'sh7FFFFFFF;
         end else if (sum34 < -34'sd2147483648) begin
            merged = 32'sh80000000;
         end else begin
            merged = sum34[31:0];
         end
      end
      mag = acc_s[31] ? -33'(acc_s) : 33'(acc_s);
      q33 = $signed({1'b0, div_quot[31:0]});
   end

   // memory, divider and handshake controls
   always_comb begin
      status.pop       = (state_ff == sra_pkg::S_IDLE) && head_valid;
      status.init_busy = (state_ff == sra_pkg::S_INIT);
      sw_wr_en    = 1'b0;
      sw_wr_addr  = fill_ff[IDXW-1:0];
      sw_rd_en    = 1'b0;
      sw_rd_addr  = idx_ff;
      bin_wr_en   = 1'b0;
      bin_wr_addr = k_ff[BIN_AW-1:0];
      acc_wr_data = merged;
      cnt_wr_data = (cnt_rd_data != sra_pkg::HITS_MAX) ? cnt_rd_data + 16'd1 : cnt_rd_data;
      bin_rd_en   = 1'b0;
      bin_rd_addr = k_ff[BIN_AW-1:0];
      div_start   = 1'b0;
      div_num     = NW'(prod_ff) << FRAC_BITS;
      div_den     = cmd_ff.sweep_stop_freq - cmd_ff.sweep_start_freq;
      case (state_ff)
         sra_pkg::S_INIT: begin
            bin_wr_en   = 1'b1;
            acc_wr_data = '0;
            cnt_wr_data = '0;
         end
         sra_pkg::S_IDLE: begin
            sw_wr_en = head_valid && (head.kind == sra_pkg::CMD_PUSH) && push_room;
         end
         sra_pkg::S_CLEAR: begin
            bin_wr_en   = 1'b1;
            acc_wr_data = clear_value;
            cnt_wr_data = '0;
         end
         sra_pkg::S_MERGE_CHK: begin
            div_start = !sweep_bad;
            div_num   = (cfg.grid_stop_freq >= cfg.grid_start_freq)
                        ? NW'(cfg.grid_stop_freq - cfg.grid_start_freq) : '0;
            div_den   = bc_wide - 32'd1;
         end
         sra_pkg::S_BIN:    bin_rd_en = 1'b1;
         sra_pkg::S_DIV_GO: div_start = 1'b1;
         sra_pkg::S_RD_LO:  sw_rd_en  = 1'b1;
         sra_pkg::S_RD_HI: begin
            sw_rd_en   = use_hi_ff;
            sw_rd_addr = idx_ff + IDXW'(1);
         end
         sra_pkg::S_WR:     bin_wr_en = merge_ok;
         sra_pkg::S_READ: begin
            bin_rd_en   = 1'b1;
            bin_rd_addr = BIN_AW'(cmd_ff.bin_index);
         end
         sra_pkg::S_READ_CALC: begin
            div_start = in_range && (cnt_rd_data != '0) && is_avg;
            div_num   = NW'(mag[31:0]);
            div_den   = 32'(cnt_rd_data);
         end
         default: begin
         end
      endcase
   end

   // datapath registers
   always_comb begin
      cmd_in    = cmd_ff;
      k_in      = k_ff;
      f_in      = f_ff;
      step_in   = step_ff;
      fill_in   = fill_ff;
      prod_in   = prod_ff;
      idx_in    = idx_ff;
      frac_in   = frac_ff;
      use_hi_in = use_hi_ff;
      lo_in     = lo_ff;
      ip_in     = ip_ff;
      mm_in     = mm_ff;
      val_in    = val_ff;
      hits_in   = hits_ff;
      neg_in    = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_hits_in  = rsp_hits_ff;
      rsp_flag_in  = rsp_flag_ff;
      case (state_ff)
         sra_pkg::S_INIT: k_in = k_ff + BCW'(1);
         sra_pkg::S_IDLE: begin
            k_in = '0;
            if (head_valid) begin
               cmd_in = head;
               if ((head.kind == sra_pkg::CMD_PUSH) && push_room) begin
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         sra_pkg::S_CLEAR: k_in = k_ff + BCW'(1);
         sra_pkg::S_MERGE_CHK: begin
            k_in = '0;
            f_in = cfg.grid_start_freq;
            if (sweep_bad) fill_in = '0;
         end
         sra_pkg::S_STEP_DIV: step_in = div_quot[31:0];
         sra_pkg::S_BIN: begin
            idx_in  = '0;
            frac_in = '0;
            if (k_ff == bc) fill_in = '0;
         end
         sra_pkg::S_MUL: begin
            prod_in = PRW'(f_ff - cmd_ff.sweep_start_freq) * PRW'(lenm1);
         end
         sra_pkg::S_POS: begin
            // clamp a position past the last sample onto it
            if (pos_int >= (NW - FRAC_BITS)'(fill_ff)) begin
               idx_in  = lenm1;
               frac_in = '0;
            end else begin
               idx_in  = IDXW'(pos_int);
               frac_in = div_quot[FRAC_BITS-1:0];
            end
         end
         sra_pkg::S_RD_LO: begin
            use_hi_in = (frac_ff != '0) && ((32'(idx_ff) + 32'd1) < 32'(fill_ff));
         end
         sra_pkg::S_RD_HI: lo_in = $signed(sw_rd_data);
         sra_pkg::S_CALC: begin
            ip_in = IPW'(diff) * IPW'($signed({1'b0, frac_ff}));
            if (is_min) begin
               mm_in = (hi_s < lo_ff) ? hi_s : lo_ff;
            end else begin
               mm_in = (hi_s > lo_ff) ? hi_s : lo_ff;
            end
         end
         sra_pkg::S_NEXT: begin
            k_in = k_ff + BCW'(1);
            f_in = f_ff + step_ff;
         end
         sra_pkg::S_READ_CALC: begin
            hits_in = in_range ? cnt_rd_data : '0;
            neg_in  = acc_s[31];
            if (!in_range || (cnt_rd_data == '0)) begin
               val_in = '0;
            end else begin
               val_in = 33'(acc_s);
            end
         end
         sra_pkg::S_READ_DIV: begin
            if (div_done) val_in = neg_ff ? -q33 : q33;
         end
         sra_pkg::S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hits_in  = hits_ff;
               rsp_flag_in  = (hits_ff != '0);
               if (val_ff > 33'(sra_pkg::VAL_MAX)) begin
                  rsp_value_in = 24'h7FFFFF;
               end else if (val_ff < 33'(sra_pkg::VAL_MIN)) begin
                  rsp_value_in = 24'h800000;
               end else begin
                  rsp_value_in = val_ff[23:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sra_pkg::S_INIT;
         k_ff         <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      f_ff         <= f_in;
      step_ff      <= step_in;
      prod_ff      <= prod_in;
      idx_ff       <= idx_in;
      frac_ff      <= frac_in;
      use_hi_ff    <= use_hi_in;
      lo_ff        <= lo_in;
      ip_ff        <= ip_in;
      mm_ff        <= mm_in;
      val_ff       <= val_in;
      hits_ff      <= hits_in;
      neg_ff       <= neg_in;
      rsp_value_ff <= rsp_value_in;
      rsp_hits_ff  <= rsp_hits_in;
      rsp_flag_ff  <= rsp_flag_in | (|unused_pad);
   end

   sra_ram #(.WIDTH(24), .DEPTH(SWEEP_DEPTH)) u_sweep_ram (
      .clock   (clock),
      .wr_en   (sw_wr_en),
      .wr_addr (sw_wr_addr),
      .wr_data (head.sample_value),
      .rd_en   (sw_rd_en),
      .rd_addr (sw_rd_addr),
      .rd_data (sw_rd_data)
   );

   sra_ram #(.WIDTH(32), .DEPTH(BIN_DEPTH)) u_accum_ram (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (bin_wr_addr),
      .wr_data (acc_wr_data),
      .rd_en   (bin_rd_en),
      .rd_addr (bin_rd_addr),
      .rd_data (acc_rd_data)
   );

   sra_ram #(.WIDTH(16), .DEPTH(BIN_DEPTH)) u_count_ram (
      .clock   (clock),
      .wr_en   (bin_wr_en),
      .wr_addr (bin_wr_addr),
      .wr_data (cnt_wr_data),
      .rd_en   (bin_rd_en),
      .rd_addr (bin_rd_addr),
      .rd_data (cnt_rd_data)
   );

   sra_div #(.NW(NW), .DW(32)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_hits_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_flag_ff;

endmodule
